### hdl/aese_pkg.sv
// Shared types and constants of the ANSI escape sequence emitter.
package aese_pkg;

    // Decimal digits allowed in a cursor coordinate; coordinates saturate to 10^N - 1.
    localparam int MAX_COORD_DIGITS = 4;

    // Width of every number carried from the front part to the back part.
    localparam int VAL_W = 14;

    // Digit places the back part has to cover: 8-bit values need three.
    localparam int NUM_DIGITS  = (MAX_COORD_DIGITS > 3) ? MAX_COORD_DIGITS : 3;
    localparam int COORD_LIMIT = (10 ** MAX_COORD_DIGITS) - 1;

    // Index of a digit place, and width of the largest multiple of a power of ten.
    localparam int PL_W  = $clog2(NUM_DIGITS);
    localparam int MUL_W = $clog2(9 * (10 ** (NUM_DIGITS - 1)) + 1);
    localparam int CMP_W = (MUL_W > VAL_W) ? MUL_W : VAL_W;

    // Up to three numbers in one sequence.
    localparam int NUMS      = 3;
    localparam int NUM_IDX_W = $clog2(NUMS);

    // Depth of the queue between the front and the back part.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_FG_RGB = 3'd0,
        OP_BG_RGB = 3'd1,
        OP_FG_256 = 3'd2,
        OP_BG_256 = 3'd3,
        OP_FG_16  = 3'd4,
        OP_BG_16  = 3'd5,
        OP_RESET  = 3'd6,
        OP_CURSOR = 3'd7
    } op_t;

    // ASCII characters used in the sequences.
    localparam logic [7:0] CH_ESC    = 8'h1b;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_FOUR   = 8'h34;
    localparam logic [7:0] CH_FIVE   = 8'h35;
    localparam logic [7:0] CH_EIGHT  = 8'h38;
    localparam logic [7:0] CH_LOW_M  = 8'h6d;
    localparam logic [7:0] CH_UP_H   = 8'h48;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // One classified request, as the back part executes it.
    typedef struct packed {
        logic                             err;       // zero cursor coordinate
        logic                             long_pfx;  // ESC [ x 8 ; y ; rather than ESC [
        logic                             bg;        // '4' rather than '3'
        logic                             rgb;       // '2' rather than '5'
        logic                             cursor;    // ends in 'H' rather than 'm'
        logic [NUM_IDX_W-1:0]             num_last;  // index of the last number
        logic [NUMS-1:0][VAL_W-1:0]       val;       // numbers to print
        logic [NUMS-1:0][PL_W-1:0]        top;       // place of each leading digit
    } desc_t;

endpackage

### hdl/aese_front.sv
// Front part: classifies one command into a sequence descriptor.
module aese_front (
    input  logic [2:0]        op,
    input  logic [7:0]        red,
    input  logic [7:0]        green,
    input  logic [7:0]        blue,
    input  logic [7:0]        pal_index,
    input  logic [13:0]       row,
    input  logic [13:0]       column,
    output aese_pkg::desc_t   desc
);

    localparam int VAL_W      = aese_pkg::VAL_W;
    localparam int PL_W       = aese_pkg::PL_W;
    localparam int NUM_DIGITS = aese_pkg::NUM_DIGITS;
    localparam int NUM_IDX_W  = aese_pkg::NUM_IDX_W;

    localparam logic [8:0] FG16_LO = 9'd30;
    localparam logic [8:0] FG16_HI = 9'd90;
    localparam logic [8:0] BG16_LO = 9'd40;
    localparam logic [8:0] BG16_HI = 9'd100;

    // Place of the leading decimal digit of a value.
    function automatic logic [PL_W-1:0] top_place(input logic [VAL_W-1:0] v);
        logic [PL_W-1:0] t;
        t = '0;
        for (int p = 1; p < NUM_DIGITS; p++) begin
            if (32'(v) >= 32'(10 ** p)) begin
                t = PL_W'(p);
            end
        end
        return t;
    endfunction

    function automatic logic [VAL_W-1:0] saturate(input logic [13:0] v);
        logic [VAL_W-1:0] s;
        s = VAL_W'(v);
        if (32'(v) > 32'(aese_pkg::COORD_LIMIT)) begin
            s = VAL_W'(aese_pkg::COORD_LIMIT);
        end
        return s;
    endfunction

    logic [8:0]       lo16;
    logic [8:0]       hi16;
    logic [8:0]       code16;
    logic [VAL_W-1:0] row_sat;
    logic [VAL_W-1:0] col_sat;

    assign lo16    = op[0] ? BG16_LO : FG16_LO;
    assign hi16    = op[0] ? BG16_HI : FG16_HI;
    assign code16  = (pal_index < 8'd8) ? (lo16 + 9'(pal_index))
                                        : (hi16 + 9'(pal_index) - 9'd8);
    assign row_sat = saturate(row);
    assign col_sat = saturate(column);

    always_comb
    begin
        desc = '0;
        unique case (aese_pkg::op_t'(op))
            aese_pkg::OP_FG_RGB, aese_pkg::OP_BG_RGB:
            begin
                desc.long_pfx = 1'b1;
                desc.bg       = op[0];
                desc.rgb      = 1'b1;
                desc.num_last = NUM_IDX_W'(2);
                desc.val[0]   = VAL_W'(red);
                desc.val[1]   = VAL_W'(green);
                desc.val[2]   = VAL_W'(blue);
                desc.top[0]   = top_place(VAL_W'(red));
                desc.top[1]   = top_place(VAL_W'(green));
                desc.top[2]   = top_place(VAL_W'(blue));
            end
            aese_pkg::OP_FG_256, aese_pkg::OP_BG_256:
            begin
                desc.long_pfx = 1'b1;
                desc.bg       = op[0];
                desc.val[0]   = VAL_W'(pal_index);
                desc.top[0]   = top_place(VAL_W'(pal_index));
            end
            aese_pkg::OP_FG_16, aese_pkg::OP_BG_16:
            begin
                desc.val[0] = VAL_W'(code16);
                desc.top[0] = top_place(VAL_W'(code16));
            end
            aese_pkg::OP_RESET:
            begin
                // Printed as ESC [ then the number zero then 'm'.
                desc.val[0] = '0;
                desc.top[0] = '0;
            end
            aese_pkg::OP_CURSOR:
            begin
                desc.err      = (row == '0) || (column == '0);
                desc.cursor   = 1'b1;
                desc.num_last = NUM_IDX_W'(1);
                desc.val[0]   = row_sat;
                desc.val[1]   = col_sat;
                desc.top[0]   = top_place(row_sat);
                desc.top[1]   = top_place(col_sat);
            end
            default:
            begin
                desc = '0;
            end
        endcase
    end

endmodule

### hdl/aese_queue.sv
// Short descriptor queue between the front and the back part.
module aese_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  aese_pkg::desc_t   wr_data,
    input  logic              rd,
    output aese_pkg::desc_t   rd_data,
    output logic              full,
    output logic              empty
);

    localparam int Q_DEPTH = aese_pkg::Q_DEPTH;
    localparam int Q_AW    = aese_pkg::Q_AW;
    localparam int Q_CW    = aese_pkg::Q_CW;

    aese_pkg::desc_t  mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg;
    logic [Q_AW-1:0]  wr_ptr_next;
    logic [Q_AW-1:0]  rd_ptr_reg;
    logic [Q_AW-1:0]  rd_ptr_next;
    logic [Q_CW-1:0]  cnt_reg;
    logic [Q_CW-1:0]  cnt_next;
    logic             do_wr;
    logic             do_rd;

    function automatic logic [Q_AW-1:0] bump(input logic [Q_AW-1:0] p);
        return (p == Q_AW'(Q_DEPTH - 1)) ? '0 : Q_AW'(p + 1'b1);
    endfunction

    assign full    = (cnt_reg == Q_CW'(Q_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_rd ? bump(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd) begin
            cnt_next = Q_CW'(cnt_reg + 1'b1);
        end else if (do_rd && !do_wr) begin
            cnt_next = Q_CW'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hdl/aese_back.sv
// Back part: byte sequencer with a digit unit and the result register.
module aese_back (
    input  logic              clk,
    input  logic              rst_n,
    input  aese_pkg::desc_t   q_head,
    input  logic              q_empty,
    output logic              q_rd,
    input  logic              pop,
    output logic              empty,
    output logic [7:0]        out_byte,
    output logic              last,
    output logic              error
);

    localparam int VAL_W      = aese_pkg::VAL_W;
    localparam int PL_W       = aese_pkg::PL_W;
    localparam int MUL_W      = aese_pkg::MUL_W;
    localparam int CMP_W      = aese_pkg::CMP_W;
    localparam int NUM_DIGITS = aese_pkg::NUM_DIGITS;
    localparam int NUM_IDX_W  = aese_pkg::NUM_IDX_W;

    localparam logic [2:0] PFX_LONG_LAST  = 3'd6;
    localparam logic [2:0] PFX_SHORT_LAST = 3'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREFIX,
        ST_DIGIT,
        ST_SEP,
        ST_FINAL,
        ST_ERR
    } state_t;

    function automatic logic [MUL_W-1:0] pow10(input logic [PL_W-1:0] p);
        logic [MUL_W-1:0] r;
        r = MUL_W'(1);
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (p == PL_W'(i)) begin
                r = MUL_W'(10 ** i);
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] prefix_byte(input logic [2:0] pos, input logic bg,
                                               input logic rgb);
        logic [7:0] b;
        unique case (pos)
            3'd0:    b = aese_pkg::CH_ESC;
            3'd1:    b = aese_pkg::CH_LBRACK;
            3'd2:    b = bg ? aese_pkg::CH_FOUR : aese_pkg::CH_THREE;
            3'd3:    b = aese_pkg::CH_EIGHT;
            3'd5:    b = rgb ? aese_pkg::CH_TWO : aese_pkg::CH_FIVE;
            default: b = aese_pkg::CH_SEMI;
        endcase
        return b;
    endfunction

    state_t               state_reg,  state_next;
    aese_pkg::desc_t      d_reg,      d_next;
    logic [2:0]           pos_reg,    pos_next;
    logic [NUM_IDX_W-1:0] num_reg,    num_next;
    logic [PL_W-1:0]      place_reg,  place_next;
    logic [VAL_W-1:0]     cur_reg,    cur_next;
    logic                 valid_reg,  valid_next;
    logic [7:0]           byte_reg,   byte_next;
    logic                 last_reg,   last_next;
    logic                 err_reg,    err_next;

    logic                 slot_free;
    logic                 load;
    logic [NUM_IDX_W-1:0] num_inc;
    logic [2:0]           pfx_last;
    logic [MUL_W-1:0]     pw;
    logic [MUL_W-1:0]     mult;
    logic [MUL_W-1:0]     sub;
    logic [3:0]           dig;
    logic [VAL_W-1:0]     cur_rem;

    // Digit unit: compare against the nine multiples of the current power of ten.
    always_comb
    begin
        pw   = pow10(place_reg);
        dig  = '0;
        sub  = '0;
        mult = '0;
        for (int d = 1; d < 10; d++) begin
            mult = MUL_W'(pw * MUL_W'(d));
            if (CMP_W'(cur_reg) >= CMP_W'(mult)) begin
                dig = 4'(d);
                sub = mult;
            end
        end
        cur_rem = VAL_W'(CMP_W'(cur_reg) - CMP_W'(sub));
    end

    assign slot_free = !valid_reg || pop;
    assign num_inc   = NUM_IDX_W'(num_reg + 1'b1);
    assign pfx_last  = d_reg.long_pfx ? PFX_LONG_LAST : PFX_SHORT_LAST;

    always_comb
    begin
        state_next = state_reg;
        d_next     = d_reg;
        pos_next   = pos_reg;
        num_next   = num_reg;
        place_next = place_reg;
        cur_next   = cur_reg;
        valid_next = valid_reg && !pop;
        byte_next  = byte_reg;
        last_next  = last_reg;
        err_next   = err_reg;
        load       = 1'b0;
        q_rd       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                load = 1'b1;
            end
            ST_PREFIX:
            begin
                if (slot_free) begin
                    valid_next = 1'b1;
                    byte_next  = prefix_byte(pos_reg, d_reg.bg, d_reg.rgb);
                    last_next  = 1'b0;
                    err_next   = 1'b0;
                    if (pos_reg == pfx_last) begin
                        state_next = ST_DIGIT;
                        num_next   = '0;
                        cur_next   = d_reg.val[0];
                        place_next = d_reg.top[0];
                    end else begin
                        pos_next = 3'(pos_reg + 1'b1);
                    end
                end
            end
            ST_DIGIT:
            begin
                if (slot_free) begin
                    valid_next = 1'b1;
                    byte_next  = aese_pkg::CH_ZERO + 8'(dig);
                    last_next  = 1'b0;
                    err_next   = 1'b0;
                    if (place_reg == '0) begin
                        state_next = (num_reg == d_reg.num_last) ? ST_FINAL : ST_SEP;
                    end else begin
                        place_next = PL_W'(place_reg - 1'b1);
                        cur_next   = cur_rem;
                    end
                end
            end
            ST_SEP:
            begin
                if (slot_free) begin
                    valid_next = 1'b1;
                    byte_next  = aese_pkg::CH_SEMI;
                    last_next  = 1'b0;
                    err_next   = 1'b0;
                    state_next = ST_DIGIT;
                    num_next   = num_inc;
                    cur_next   = d_reg.val[num_inc];
                    place_next = d_reg.top[num_inc];
                end
            end
            ST_FINAL:
            begin
                if (slot_free) begin
                    valid_next = 1'b1;
                    byte_next  = d_reg.cursor ? aese_pkg::CH_UP_H : aese_pkg::CH_LOW_M;
                    last_next  = 1'b1;
                    err_next   = 1'b0;
                    load       = 1'b1;
                end
            end
            ST_ERR:
            begin
                if (slot_free) begin
                    valid_next = 1'b1;
                    byte_next  = aese_pkg::CH_NUL;
                    last_next  = 1'b1;
                    err_next   = 1'b1;
                    load       = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Take the next descriptor as the current request finishes.
        if (load) begin
            if (!q_empty) begin
                q_rd       = 1'b1;
                d_next     = q_head;
                pos_next   = '0;
                state_next = q_head.err ? ST_ERR : ST_PREFIX;
            end else begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            d_reg     <= '0;
            pos_reg   <= '0;
            num_reg   <= '0;
            place_reg <= '0;
            cur_reg   <= '0;
            valid_reg <= 1'b0;
            byte_reg  <= '0;
            last_reg  <= 1'b0;
            err_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            d_reg     <= d_next;
            pos_reg   <= pos_next;
            num_reg   <= num_next;
            place_reg <= place_next;
            cur_reg   <= cur_next;
            valid_reg <= valid_next;
            byte_reg  <= byte_next;
            last_reg  <= last_next;
            err_reg   <= err_next;
        end
    end

    assign empty    = !valid_reg;
    assign out_byte = byte_reg;
    assign last     = last_reg;
    assign error    = err_reg;

endmodule

### hdl/ansi_escape_sequence_emitter_top.sv
// Top level of the ANSI escape sequence emitter: front part, queue and back part.
//
//   Channel   Handshake          Contents
//   command   push / full        op, red, green, blue, pal_index, row, column
//   result    empty / pop        out_byte, last, error
//
// Each command request becomes one result per byte of its escape sequence, from 4
// bytes (reset) to 19 bytes (24-bit colour), or a single error result for a cursor
// move to row or column zero. The back part's sequencer emits one byte per cycle
// while the result port is not stalled, and that sequencer sets the sustained
// rate. When the back part is idle, the first byte of a request passes the queue
// and the sequencer's idle state before it reaches the result register. The front
// part classifies a command in the cycle it is accepted and writes it to a
// two-entry queue, so commands keep being accepted while the back part works or
// while the result port is stalled, until that queue is full. The asynchronous
// reset empties the queue and the result register.
module ansi_escape_sequence_emitter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  op,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  pal_index,
    input  logic [13:0] row,
    input  logic [13:0] column,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic        error
);

    aese_pkg::desc_t front_desc;
    aese_pkg::desc_t q_head;
    logic            q_full;
    logic            q_empty;
    logic            q_rd;

    // The front part decodes the operands and works out digit counts.
    aese_front u_front (
        .op        (op),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .pal_index (pal_index),
        .row       (row),
        .column    (column),
        .desc      (front_desc)
    );

    // The queue decouples command acceptance from byte emission.
    aese_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (push),
        .wr_data (front_desc),
        .rd      (q_rd),
        .rd_data (q_head),
        .full    (q_full),
        .empty   (q_empty)
    );

    // The back part walks each descriptor one byte at a time.
    aese_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_head   (q_head),
        .q_empty  (q_empty),
        .q_rd     (q_rd),
        .pop      (pop),
        .empty    (empty),
        .out_byte (out_byte),
        .last     (last),
        .error    (error)
    );

    assign full = q_full;

    // The sequencer never takes a descriptor from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_rd |-> !q_empty)
        else $error("descriptor taken from an empty queue");

    // An error result stands alone: it ends its request and carries no character.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && error) |-> (last && (out_byte == aese_pkg::CH_NUL)))
        else $error("error result is not a lone null byte");

    // No byte of a real sequence is the null byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !error) |-> (out_byte != aese_pkg::CH_NUL))
        else $error("null byte inside an escape sequence");

endmodule

### bench/tb.sv
// Self-checking testbench for the ANSI escape sequence emitter.
`timescale 1ns / 1ps

module tb;
    import aese_pkg::*;

    // The watchdog ends the run after this many cycles in which no request and
    // no result byte is accepted. The longest quiet stretch of a correct run is
    // the deliberate output hold-off below, so the limit sits well above it.
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_PRINTED  = 40;
    localparam int TAIL_CYCLES  = 60;

    // One byte of an escape sequence as it leaves the block.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       error;
    } seq_byte_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [2:0]  op;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  pal_index;
    logic [13:0] row;
    logic [13:0] column;
    logic        empty;
    logic        pop;
    logic [7:0]  out_byte;
    logic        last;
    logic        error;

    // Bytes the emitter still owes, oldest first, and scratch space in which
    // one sequence is assembled before it is appended there.
    seq_byte_t   pending_bytes[$];
    logic [7:0]  seq_buf[$];

    // Idling knobs shared by the test tasks, the sender and the result drain.
    int          tx_gap_max   = 14;
    int          rx_stall_max = 14;
    int          hold_request = 0;

    int          mismatch_count  = 0;
    int          results_checked = 0;
    int          requests_sent   = 0;
    int          error_results   = 0;
    int          drain_pauses    = 0;
    int          op_seen[8];

    ansi_escape_sequence_emitter_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .op          (op),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .pal_index   (pal_index),
        .row         (row),
        .column      (column),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .last        (last),
        .error       (error)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Appends one character to the sequence being assembled.
    function automatic void add_char(logic [7:0] c);
        seq_buf = {seq_buf, c};
    endfunction

    // Appends one expected result to the owed bytes.
    function automatic void owe_byte(seq_byte_t b);
        pending_bytes = {pending_bytes, b};
    endfunction

    // Appends the decimal digits of a value, most significant first, with no
    // leading zeros; zero itself is written as a single '0'.
    function automatic void put_decimal(int unsigned value);
        logic [7:0] digits[10];
        int         n;
        n = 0;
        do
        begin
            digits[n] = CH_ZERO + 8'(value % 10);
            value     = value / 10;
            n++;
        end
        while (value != 0);
        while (n > 0)
        begin
            n--;
            add_char(digits[n]);
        end
    endfunction

    // Works out the byte stream for one accepted request and queues it.
    function automatic void predict_command(op_t cmd, logic [7:0] r, logic [7:0] g,
                                            logic [7:0] b, logic [7:0] idx,
                                            logic [13:0] y, logic [13:0] x);
        int unsigned code;
        int unsigned y_sat;
        int unsigned x_sat;
        seq_byte_t   item;
        seq_buf.delete();
        case (cmd)
            OP_FG_RGB, OP_BG_RGB, OP_FG_256, OP_BG_256:
            begin
                // Long prefix: ESC [ 3|4 8 ; 2|5 ;
                add_char(CH_ESC);
                add_char(CH_LBRACK);
                add_char((cmd == OP_BG_RGB || cmd == OP_BG_256) ? CH_FOUR : CH_THREE);
                add_char(CH_EIGHT);
                add_char(CH_SEMI);
                add_char((cmd == OP_FG_RGB || cmd == OP_BG_RGB) ? CH_TWO : CH_FIVE);
                add_char(CH_SEMI);
                if (cmd == OP_FG_RGB || cmd == OP_BG_RGB)
                begin
                    put_decimal(r);
                    add_char(CH_SEMI);
                    put_decimal(g);
                    add_char(CH_SEMI);
                    put_decimal(b);
                end
                else
                begin
                    put_decimal(idx);
                end
                add_char(CH_LOW_M);
            end
            OP_FG_16, OP_BG_16:
            begin
                // Indexes past 15 follow the same arithmetic; nothing is clamped.
                if (idx < 8)
                    code = ((cmd == OP_FG_16) ? 30 : 40) + idx;
                else
                    code = ((cmd == OP_FG_16) ? 90 : 100) + idx - 8;
                add_char(CH_ESC);
                add_char(CH_LBRACK);
                put_decimal(code);
                add_char(CH_LOW_M);
            end
            OP_RESET:
            begin
                add_char(CH_ESC);
                add_char(CH_LBRACK);
                add_char(CH_ZERO);
                add_char(CH_LOW_M);
            end
            default:
            begin
                // A zero coordinate yields a lone error byte and no sequence.
                if (y == 0 || x == 0)
                begin
                    item = '{ch: CH_NUL, last: 1'b1, error: 1'b1};
                    owe_byte(item);
                    error_results++;
                    return;
                end
                // Coordinates beyond the digit budget saturate to the limit.
                y_sat = (y > COORD_LIMIT) ? COORD_LIMIT : y;
                x_sat = (x > COORD_LIMIT) ? COORD_LIMIT : x;
                add_char(CH_ESC);
                add_char(CH_LBRACK);
                put_decimal(y_sat);
                add_char(CH_SEMI);
                put_decimal(x_sat);
                add_char(CH_UP_H);
            end
        endcase
        foreach (seq_buf[k])
        begin
            item = '{ch: seq_buf[k], last: (k == seq_buf.size() - 1), error: 1'b0};
            owe_byte(item);
        end
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch at %0t ns, result %0d: %s is %0h, expected %0h",
                     $time, results_checked, what, got, want);
    endtask

    // Offers one request. Inputs change only on the falling edge. Push is left
    // high after the acceptance so that a back-to-back request keeps it high
    // without a dip; whoever stops sending calls stop_sending.
    task automatic send_command(op_t cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                logic [7:0] idx, logic [13:0] y, logic [13:0] x);
        int gap;
        gap = (tx_gap_max > 0) ? $urandom_range(tx_gap_max, 0) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        op          <= cmd;
        red         <= r;
        green       <= g;
        blue        <= b;
        pal_index   <= idx;
        row         <= y;
        column      <= x;
        push        <= 1'b1;
        do
            @(posedge clk);
        while (full);
        predict_command(cmd, r, g, b, idx, y, x);
        requests_sent++;
        op_seen[cmd]++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        push <= 1'b0;
    endtask

    // Palette and colour values lean toward the edges of the digit counts.
    function automatic logic [7:0] pick_octet();
        logic [7:0] marks[4] = '{8'd9, 8'd10, 8'd99, 8'd100};
        case ($urandom_range(7, 0))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return marks[$urandom_range(3, 0)];
            default: return 8'($urandom);
        endcase
    endfunction

    // Coordinates are mostly legal, with a few zeros and a few past the limit.
    function automatic logic [13:0] pick_coord();
        logic [13:0] marks[8] = '{14'd1, 14'd9, 14'd10, 14'd99, 14'd100, 14'd999,
                                  14'd1000, 14'd9999};
        case ($urandom_range(15, 0))
            0:       return 14'd0;
            1:       return 14'($urandom_range(16383, 10000));
            2:       return marks[$urandom_range(7, 0)];
            3, 4, 5: return 14'($urandom_range(99, 1));
            default: return 14'($urandom_range(9999, 1));
        endcase
    endfunction

    task automatic send_random_command();
        op_t cmd;
        cmd = op_t'($urandom_range(7, 0));
        // Operands that the command ignores are random too.
        send_command(cmd, pick_octet(), pick_octet(), pick_octet(), pick_octet(),
                     pick_coord(), pick_coord());
    endtask

    // Stops offering requests until every owed byte has come out, then idles a
    // little longer so the back part is surely empty.
    task automatic wait_for_drain();
        stop_sending();
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (8) @(negedge clk);
        drain_pauses++;
    endtask

    task automatic test_color_extremes();
        send_command(OP_FG_RGB, 8'd0, 8'd0, 8'd0, 8'd0, 14'd0, 14'd0);
        send_command(OP_FG_RGB, 8'd255, 8'd255, 8'd255, 8'd255, 14'd16383, 14'd16383);
        send_command(OP_BG_RGB, 8'd7, 8'd100, 8'd42, 8'd0, 14'd1, 14'd1);
        send_command(OP_FG_256, 8'd255, 8'd255, 8'd255, 8'd0, 14'd0, 14'd0);
        send_command(OP_BG_256, 8'd0, 8'd0, 8'd0, 8'd255, 14'd0, 14'd0);
        send_command(OP_RESET, 8'd255, 8'd255, 8'd255, 8'd255, 14'd16383, 14'd16383);
    endtask

    // Both halves of the 16-colour table, plus indexes far past 15.
    task automatic test_sixteen_color_codes();
        send_command(OP_FG_16, 8'd0, 8'd0, 8'd0, 8'd0, 14'd0, 14'd0);
        send_command(OP_FG_16, 8'd0, 8'd0, 8'd0, 8'd7, 14'd0, 14'd0);
        send_command(OP_FG_16, 8'd0, 8'd0, 8'd0, 8'd8, 14'd0, 14'd0);
        send_command(OP_FG_16, 8'd0, 8'd0, 8'd0, 8'd15, 14'd0, 14'd0);
        send_command(OP_FG_16, 8'd0, 8'd0, 8'd0, 8'd255, 14'd0, 14'd0);
        send_command(OP_BG_16, 8'd0, 8'd0, 8'd0, 8'd0, 14'd0, 14'd0);
        send_command(OP_BG_16, 8'd0, 8'd0, 8'd0, 8'd8, 14'd0, 14'd0);
        send_command(OP_BG_16, 8'd0, 8'd0, 8'd0, 8'd255, 14'd0, 14'd0);
    endtask

    // Smallest and largest coordinates, saturation, and every zero pattern.
    task automatic test_cursor_limits();
        send_command(OP_CURSOR, 8'd0, 8'd0, 8'd0, 8'd0, 14'd1, 14'd1);
        send_command(OP_CURSOR, 8'd0, 8'd0, 8'd0, 8'd0, 14'd9999, 14'd9999);
        send_command(OP_CURSOR, 8'd0, 8'd0, 8'd0, 8'd0, 14'd16383, 14'd10000);
        send_command(OP_CURSOR, 8'd0, 8'd0, 8'd0, 8'd0, 14'd0, 14'd5);
        send_command(OP_CURSOR, 8'd0, 8'd0, 8'd0, 8'd0, 14'd5, 14'd0);
        send_command(OP_CURSOR, 8'd0, 8'd0, 8'd0, 8'd0, 14'd0, 14'd0);
        send_command(OP_CURSOR, 8'd0, 8'd0, 8'd0, 8'd0, 14'd10, 14'd99);
    endtask

    // The result side stops popping for a long stretch while requests keep
    // coming back to back, so the queue fills and full has to hold the sender.
    task automatic test_full_stall();
        tx_gap_max   = 0;
        hold_request = HOLD_CYCLES;
        repeat (16) send_random_command();
        tx_gap_max   = 14;
    endtask

    task automatic test_random_mix(int count);
        repeat (count) send_random_command();
    endtask

    // A stretch with neither side idling, which runs at the sequencer's rate.
    task automatic test_no_idle_burst(int count);
        tx_gap_max   = 0;
        rx_stall_max = 0;
        repeat (count) send_random_command();
        tx_gap_max   = 14;
        rx_stall_max = 14;
    endtask

    // Result side: stalls a random number of cycles before each byte, or a long
    // stretch when a test asks for it, then checks the byte at the edge where
    // it is taken against the oldest owed byte.
    initial
    begin : result_drain
        int        stall;
        seq_byte_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall        = hold_request;
                hold_request = 0;
            end
            else
            begin
                stall = (rx_stall_max > 0) ? $urandom_range(rx_stall_max, 0) : 0;
            end
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            if (pending_bytes.size() == 0)
            begin
                report_mismatch("unrequested result byte", out_byte, CH_NUL);
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (out_byte !== want.ch)
                    report_mismatch("out_byte", out_byte, want.ch);
                if (last !== want.last)
                    report_mismatch("last", {7'd0, last}, {7'd0, want.last});
                if (error !== want.error)
                    report_mismatch("error", {7'd0, error}, {7'd0, want.error});
            end
            results_checked++;
        end
    end

    // Watchdog: a long run of cycles with no handshake on either side means the
    // block has hung, so the run is ended as a failure.
    initial
    begin : hang_watch
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d bytes still owed",
                         quiet, pending_bytes.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Main sequence: reset once, the directed checks, then the pressure phases
    // and the random traffic, with a full drain between some of them.
    initial
    begin : main_flow
        int kinds;
        rst_n       = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        op          = '0;
        red         = '0;
        green       = '0;
        blue        = '0;
        pal_index   = '0;
        row         = '0;
        column      = '0;
        foreach (op_seen[k])
            op_seen[k] = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_color_extremes();
        test_sixteen_color_codes();
        test_cursor_limits();
        wait_for_drain();

        test_full_stall();
        test_random_mix(200);
        wait_for_drain();

        test_no_idle_burst(100);
        test_random_mix(150);
        stop_sending();

        // Let everything owed come out, then give the block time to show any
        // extra byte it should not produce.
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        kinds = 0;
        foreach (op_seen[k])
            if (op_seen[k] > 0)
                kinds++;
        $display("covered %0d requests across %0d of 8 command kinds, %0d result bytes checked",
                 requests_sent, kinds, results_checked);
        $display("%0d zero-coordinate errors, one long output hold-off, %0d drain pauses",
                 error_results, drain_pauses);
        if (mismatch_count == 0 && pending_bytes.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("%0d mismatches, %0d bytes never arrived",
                     mismatch_count, pending_bytes.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
